/* rtl/glyph_blit_4bpp_tiles_top_defines.svh */
// Assertion macros shared by the glyph blitter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GLYPH_BLIT_4BPP_TILES_TOP_DEFINES_SVH
`define GLYPH_BLIT_4BPP_TILES_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gbt_pkg.sv */
// Package for the glyph blitter: command, result and memory request types,
// op codes and fixed constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gbt_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_GLYPH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [7:0]  CODE_FIRST   = 8'h18;
    localparam logic [7:0]  SCREEN_LIMIT = 8'd240;
    localparam logic [31:0] INK_SPREAD   = 32'h1111_1111;
    localparam logic [3:0]  NIB_ONES     = 4'h0F;
    localparam int          MEM_AW_MAX   = 9;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [63:0] glyph_bits;
        logic [3:0]  glyph_width;
        logic [7:0]  start_x;
        logic [3:0]  pen_colour;
        logic [7:0]  word_addr;
        logic [31:0] write_data;
    } t_cmd;

    typedef struct packed {
        logic [31:0] read_data;
        logic [7:0]  pen_x;
        logic        stopped;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [MEM_AW_MAX-1:0] waddr;
        logic [31:0]           wdata;
        logic                  re;
        logic [MEM_AW_MAX-1:0] raddr;
    } t_mem_req;

    function automatic logic [31:0] nib_mask(input logic [7:0] m);
        logic [31:0] v;
        v = 32'd0;
        for (int j = 0; j < 8; j++) begin
            v[4*j +: 4] = m[j] ? NIB_ONES : 4'h0;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/glyph_blit_4bpp_tiles_top.sv */
// Glyph blitter top: 4-bpp tiled canvas, one result per command.
// Start/write ops, stopped glyph: result in the cycle after transfer. Read and glyph:
// ST_RD state or ST_GLY pass (16 word read-modify-writes on the canvas ports), then
// output register. Next command is taken in the cycle the result shows; the receiver
// cannot stall. After reset busy stays high while the canvas is cleared.
`timescale 1ns / 1ps
`default_nettype none

module glyph_blit_4bpp_tiles_top #(
    parameter int CANVAS_TILES = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire gbt_pkg::t_cmd    i_cmd,
    output logic                  o_done,
    output gbt_pkg::t_result      o_result
);

    gbt_pkg::t_mem_req mem_req;
    logic [31:0]       mem_q;
    logic              res_valid;
    gbt_pkg::t_result  res;
    logic              seq_busy;

    logic             r_done;
    gbt_pkg::t_result r_result;

    gbt_seq #(
        .CANVAS_TILES(CANVAS_TILES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .o_busy      (seq_busy),
        .o_mem_req   (mem_req),
        .i_mem_q     (mem_q),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    gbt_canvas_mem #(
        .CANVAS_TILES(CANVAS_TILES)
    ) u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_q   (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_result <= res;
        end
    end

    assign busy     = seq_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/gbt_canvas_mem.sv */
// Canvas word memory: one write port, one read port, registered read data.
// Depends on gbt_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module gbt_canvas_mem #(
    parameter int CANVAS_TILES = 32
) (
    input  wire logic              i_clk,
    input  wire gbt_pkg::t_mem_req i_req,
    output logic [31:0]            o_q
);

    localparam int WORDS = CANVAS_TILES * 8;
    localparam int AW    = $clog2(WORDS);

    logic [31:0] mem [WORDS];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

/* rtl/gbt_seq.sv */
// Blit sequencer: pen state, clear sweep, op decode and the glyph
// read-modify-write pipeline. Depends on gbt_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_blit_4bpp_tiles_top_defines.svh"

module gbt_seq #(
    parameter int CANVAS_TILES = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire gbt_pkg::t_cmd     i_cmd,
    output logic                   o_busy,
    output gbt_pkg::t_mem_req      o_mem_req,
    input  wire logic [31:0]       i_mem_q,
    output logic                   o_res_valid,
    output gbt_pkg::t_result       o_res
);

    localparam int WORDS = CANVAS_TILES * 8;
    localparam int AW    = $clog2(WORDS);
    localparam int MAW   = gbt_pkg::MEM_AW_MAX;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;
    localparam logic [1:0] ST_GLY   = 2'd3;

    localparam logic [4:0] GLY_LAST = 5'd16;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [4:0]    r_cnt, n_cnt;
    logic [7:0]    r_pen, n_pen;
    logic [3:0]    r_ink, n_ink;
    logic [63:0]   r_bits, n_bits;
    logic [4:0]    r_tile, n_tile;
    logic [2:0]    r_off, n_off;
    logic [MAW-1:0] r_wa, n_wa;
    logic [7:0]    r_wm, n_wm;
    logic          r_we, n_we;
    logic          r_rd_ok, n_rd_ok;

    gbt_pkg::t_mem_req mem_req;
    gbt_pkg::t_result  res;
    logic              res_valid;

    logic           addr_ok;
    logic           stop_hit;
    logic [8:0]     pen_sum;
    logic [2:0]     row;
    logic           half;
    logic [5:0]     tile_full;
    logic [MAW-1:0] word;
    logic           word_ok;
    logic [7:0]     line;
    logic [15:0]    mask16;
    logic [31:0]    nm;
    logic [31:0]    ink_word;

    always_comb begin
        addr_ok   = 32'(i_cmd.word_addr) < 32'(WORDS);
        stop_hit  = (i_cmd.char_code < gbt_pkg::CODE_FIRST) || (r_pen >= gbt_pkg::SCREEN_LIMIT);
        pen_sum   = {1'b0, r_pen} + 9'(i_cmd.glyph_width);
        row       = r_cnt[3:1];
        half      = r_cnt[0];
        tile_full = {1'b0, r_tile} + 6'(half);
        word      = {tile_full, row};
        word_ok   = 32'(word) < 32'(WORDS);
        line      = r_bits[{row, 3'b000} +: 8];
        mask16    = 16'(line) << r_off;
        nm        = gbt_pkg::nib_mask(r_wm);
        ink_word  = gbt_pkg::INK_SPREAD * 32'(r_ink);
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_pen   = r_pen;
        n_ink   = r_ink;
        n_bits  = r_bits;
        n_tile  = r_tile;
        n_off   = r_off;
        n_wa    = r_wa;
        n_wm    = r_wm;
        n_we    = 1'b0;
        n_rd_ok = r_rd_ok;

        mem_req   = '0;
        res_valid = 1'b0;
        res.read_data = 32'd0;
        res.pen_x     = r_pen;
        res.stopped   = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MAW'(r_clr);
                mem_req.wdata = 32'd0;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    case (i_cmd.op)
                        gbt_pkg::OP_START: begin
                            n_pen       = i_cmd.start_x;
                            n_ink       = i_cmd.pen_colour;
                            res_valid   = 1'b1;
                            res.pen_x   = i_cmd.start_x;
                        end
                        gbt_pkg::OP_GLYPH: begin
                            if (stop_hit) begin
                                res_valid   = 1'b1;
                                res.stopped = 1'b1;
                            end else begin
                                n_bits  = i_cmd.glyph_bits;
                                n_tile  = r_pen[7:3];
                                n_off   = r_pen[2:0];
                                n_pen   = pen_sum[8] ? 8'hFF : pen_sum[7:0];
                                n_cnt   = 5'd0;
                                n_state = ST_GLY;
                            end
                        end
                        gbt_pkg::OP_READ: begin
                            mem_req.re    = addr_ok;
                            mem_req.raddr = MAW'(i_cmd.word_addr);
                            n_rd_ok       = addr_ok;
                            n_state       = ST_RD;
                        end
                        gbt_pkg::OP_WRITE: begin
                            mem_req.we    = addr_ok;
                            mem_req.waddr = MAW'(i_cmd.word_addr);
                            mem_req.wdata = i_cmd.write_data;
                            res_valid     = 1'b1;
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD: begin
                res_valid     = 1'b1;
                res.read_data = r_rd_ok ? i_mem_q : 32'd0;
                n_state       = ST_IDLE;
            end
            ST_GLY: begin
                // write back the word read last cycle
                mem_req.we    = r_we;
                mem_req.waddr = r_wa;
                mem_req.wdata = (i_mem_q & ~nm) | (ink_word & nm);
                if (!r_cnt[4]) begin
                    mem_req.re    = word_ok;
                    mem_req.raddr = word;
                    n_wa  = word;
                    n_wm  = half ? mask16[15:8] : mask16[7:0];
                    n_we  = word_ok;
                    n_cnt = r_cnt + 5'd1;
                end
                if (r_cnt == GLY_LAST) begin
                    res_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_cnt   <= 5'd0;
            r_pen   <= 8'd0;
            r_ink   <= 4'd0;
            r_we    <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_pen   <= n_pen;
            r_ink   <= n_ink;
            r_we    <= n_we;
            r_rd_ok <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_tile <= n_tile;
        r_off  <= n_off;
        r_wa   <= n_wa;
        r_wm   <= n_wm;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_mem_req   = mem_req;
    assign o_res_valid = res_valid;
    assign o_res       = res;

    `GBT_ASSERT_IMP(a_clear_zero, i_clk, i_rst_n, r_state == ST_CLEAR, mem_req.we && mem_req.wdata == 32'd0, "clear sweep must write zero")
    `GBT_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !res_valid, "result during clear sweep")
    `GBT_ASSERT_IMP(a_rmw_disjoint, i_clk, i_rst_n, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit one word")
    `GBT_ASSERT_NXT(a_gly_end, i_clk, i_rst_n, r_state == ST_GLY && r_cnt == GLY_LAST, r_state == ST_IDLE, "glyph pass did not end")

endmodule

`default_nettype wire

/* tb/sv/canvas_scoreboard_pkg.sv */
// Scoreboard for the glyph blitter: tracks canvas, pen and ink, predicts each result.
// Depends on gbt_pkg for the command and result types and the op codes.
`timescale 1ns / 1ps

package canvas_scoreboard_pkg;

    import gbt_pkg::*;

    class canvas_scoreboard;

        logic [31:0] canvas [];
        int          words;
        logic [7:0]  pen_pos;
        logic [3:0]  pen_ink;
        t_result     expected_q [$];
        int          errors;

        function new(int tiles);
            words    = tiles * 8;
            canvas   = new[words];
            foreach (canvas[k]) canvas[k] = 32'd0;
            pen_pos  = 8'd0;
            pen_ink  = 4'd0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void paint(int px, int row);
            int word;
            int sh;
            word = (px >> 3) * 8 + row;
            sh   = (px & 7) * 4;
            if (word < words) begin
                canvas[word][sh +: 4] = pen_ink;
            end
        endfunction

        function void stamp_glyph(logic [63:0] bits);
            for (int r = 0; r < 8; r++) begin
                for (int i = 0; i < 8; i++) begin
                    if (bits[8*r + i]) begin
                        paint(int'(pen_pos) + i, r);
                    end
                end
            end
        endfunction

        function void note_cmd(t_cmd c);
            t_result     r;
            logic [8:0]  nx;
            r = '0;
            case (c.op)
                OP_START: begin
                    pen_pos = c.start_x;
                    pen_ink = c.pen_colour;
                end
                OP_GLYPH: begin
                    if (c.char_code < CODE_FIRST || pen_pos >= SCREEN_LIMIT) begin
                        r.stopped = 1'b1;
                    end else begin
                        stamp_glyph(c.glyph_bits);
                        nx      = {1'b0, pen_pos} + {5'd0, c.glyph_width};
                        pen_pos = (nx > 9'd255) ? 8'd255 : nx[7:0];
                    end
                end
                OP_READ: begin
                    if (int'(c.word_addr) < words) begin
                        r.read_data = canvas[c.word_addr];
                    end
                end
                default: begin
                    if (int'(c.word_addr) < words) begin
                        canvas[c.word_addr] = c.write_data;
                    end
                end
            endcase
            r.pen_x = pen_pos;
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [31:0] e, logic [31:0] a);
            errors++;
            if (errors <= 10) begin
                $display("ERROR %s: expected %0h, got %0h", field, e, a);
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result %0h with no transfer pending", got);
                end
                return;
            end
            e = expected_q.pop_front();
            if (got.read_data !== e.read_data) report("read_data", e.read_data, got.read_data);
            if (got.pen_x !== e.pen_x) report("pen_x", {24'd0, e.pen_x}, {24'd0, got.pen_x});
            if (got.stopped !== e.stopped) report("stopped", {31'd0, e.stopped}, {31'd0, got.stopped});
        endfunction

    endclass

endpackage

/* tb/sv/testbench.sv */
// Testbench top for glyph_blit_4bpp_tiles_top: directed and random commands, checked
// against canvas_scoreboard. Depends on gbt_pkg and canvas_scoreboard_pkg.
`timescale 1ns / 1ps

module testbench;

    import gbt_pkg::*;
    import canvas_scoreboard_pkg::*;

    localparam int TILES        = 32;
    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_ITEMS   = 100;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_cmd    i_cmd   = '0;
    logic    o_done;
    t_result o_result;

    canvas_scoreboard sb;
    int               accepted_count = 0;
    bit               gaps_on = 1'b0;

    glyph_blit_4bpp_tiles_top #(
        .CANVAS_TILES(TILES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_result);
        end
    end

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.op          = 2'($urandom_range(0, 3));
        c.char_code   = 8'($urandom);
        c.glyph_bits  = {$urandom, $urandom};
        c.glyph_width = 4'($urandom);
        c.start_x     = 8'($urandom);
        c.pen_colour  = 4'($urandom);
        c.word_addr   = 8'($urandom);
        c.write_data  = $urandom;
        return c;
    endfunction

    function automatic t_cmd cmd_of(logic [1:0] op, logic [7:0] code, logic [63:0] bits,
                                    logic [3:0] width, logic [7:0] x, logic [3:0] colour,
                                    logic [7:0] addr, logic [31:0] data);
        t_cmd c;
        c = '{op, code, bits, width, x, colour, addr, data};
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_cmd(c);
        accepted_count++;
    endtask

    task automatic maybe_pause();
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            i_cmd <= random_cmd();
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input t_cmd c);
        send_cmd(c);
        maybe_pause();
    endtask

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int   kind;
        int   n;
        int   x0;
        int   stop_at;
        t_cmd c;

        sb = new(TILES);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'hFF, '1, 4'hF, 8'hFF, 4'hF, 8'hFF, 32'hFFFF_FFFF));
        send_cmd(cmd_of(OP_WRITE, 8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h00, 32'hFFFF_FFFF));
        send_cmd(cmd_of(OP_WRITE, 8'hFF, '1, 4'hF, 8'hFF, 4'hF, 8'hFF, 32'hFFFF_FFFF));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'hFF, 32'h0));
        send_cmd(cmd_of(OP_WRITE, 8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_START, 8'h00, '0, 4'h0, 8'h00, 4'hF, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, CODE_FIRST, '1, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h09, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h17, '1, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h00, '1, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'hFF, '0, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_START, 8'h00, '0, 4'h0, 8'h05, 4'hA, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h41, '1, 4'h8, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h07, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'h0F, 32'h0));
        send_cmd(cmd_of(OP_START, 8'h00, '0, 4'h0, 8'd239, 4'h3, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h80, {$urandom, $urandom}, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h80, '1, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_START, 8'h00, '0, 4'h0, SCREEN_LIMIT, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h80, '1, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_START, 8'h00, '0, 4'h0, 8'hFF, 4'h5, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_GLYPH, 8'h80, '1, 4'hF, 8'h00, 4'h0, 8'h00, 32'h0));
        send_cmd(cmd_of(OP_READ,  8'h00, '0, 4'h0, 8'h00, 4'h0, 8'd247, 32'h0));

        stop_at = accepted_count + RANDOM_ITEMS;
        while (accepted_count < stop_at) begin
            gaps_on = (accepted_count < stop_at - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            if (kind < 7) begin
                c         = random_cmd();
                c.op      = OP_START;
                c.start_x = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 200));
                x0        = int'(c.start_x);
                send_random(c);
                n = $urandom_range(2, 8);
                repeat (n) begin
                    c    = random_cmd();
                    c.op = OP_GLYPH;
                    if ($urandom_range(0, 9) == 0) begin
                        c.char_code = 8'($urandom_range(0, 8'h17));
                    end else begin
                        c.char_code = 8'($urandom_range(8'h18, 255));
                    end
                    send_random(c);
                end
                n = $urandom_range(1, 3);
                repeat (n) begin
                    c           = random_cmd();
                    c.op        = OP_READ;
                    c.word_addr = 8'(((x0 >> 3) + $urandom_range(0, 3)) * 8 + $urandom_range(0, 7));
                    send_random(c);
                end
            end else if (kind < 9) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    c    = random_cmd();
                    c.op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
                    send_random(c);
                end
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_random(random_cmd());
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* glyph_blit_4bpp_tiles_top.f */
+incdir+rtl
rtl/gbt_pkg.sv
rtl/gbt_canvas_mem.sv
rtl/gbt_seq.sv
rtl/glyph_blit_4bpp_tiles_top.sv
tb/sv/canvas_scoreboard_pkg.sv
tb/sv/testbench.sv
